// ===== hw/rtl/mfe_pkg.sv =====
// Shared types, constants and the sequencer control store for the meter frame encoder.
// No dependencies; imported by meter_frame_encoder.
package mfe_pkg;

  localparam int ADDR_BYTES = 6;
  localparam int IDX_W      = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;
  localparam int CNT_W      = $clog2(ADDR_BYTES + 1);
  localparam int UPC_W      = 5;

  localparam logic [7:0] FILL_BYTE   = 8'hFC;
  localparam logic [7:0] SOF_BYTE    = 8'h68;
  localparam logic [7:0] BODY_OFFSET = 8'h33;
  localparam logic [7:0] END_BYTE    = 8'h16;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_TARGET  = 2'd1,
    OP_RELAY   = 2'd2,
    OP_PAYLOAD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TARGET  = 2'd1,
    PH_RELAY   = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  // byte source for an emitting step
  typedef enum logic [3:0] {
    SRC_NONE    = 4'd0,
    SRC_FILL    = 4'd1,
    SRC_SOF     = 4'd2,
    SRC_DATA    = 4'd3,
    SRC_DATA33  = 4'd4,
    SRC_RELAY   = 4'd5,
    SRC_CTRL    = 4'd6,
    SRC_LEN     = 4'd7,
    SRC_STORE33 = 4'd8,
    SRC_SUM     = 4'd9,
    SRC_END     = 4'd10
  } src_t;

  typedef enum logic [3:0] {
    COND_NEVER        = 4'd0,
    COND_ALWAYS       = 4'd1,
    COND_RELAYS_ZERO  = 4'd2,
    COND_RELAYS_NZ    = 4'd3,
    COND_BC_NE_ADDR   = 4'd4,
    COND_BC_LT_RELAYS = 4'd5,
    COND_LEN_ZERO     = 4'd6,
    COND_BC_LT_LEN    = 4'd7,
    COND_IDX_NE_LAST  = 4'd8
  } cond_t;

  typedef enum logic [1:0] {
    BC_HOLD = 2'd0,
    BC_CLR  = 2'd1,
    BC_INC  = 2'd2
  } bc_op_t;

  typedef struct packed {
    src_t               src;
    logic               sum;
    logic               cs_clr;
    logic               store_wr;
    bc_op_t             bc_op;
    logic               idx_clr;
    logic               idx_inc;
    logic               ph_wr;
    phase_t             ph;
    cond_t              cond;
    logic [UPC_W-1:0]   target;
    logic               fin;
  } uword_t;

  // control store addresses
  localparam logic [UPC_W-1:0] US_FILL0     = 5'd0;
  localparam logic [UPC_W-1:0] US_FILL1     = 5'd1;
  localparam logic [UPC_W-1:0] US_SOF       = 5'd2;
  localparam logic [UPC_W-1:0] US_TGT       = 5'd3;
  localparam logic [UPC_W-1:0] US_TGT_EMIT  = 5'd4;
  localparam logic [UPC_W-1:0] US_TGT_TEST  = 5'd5;
  localparam logic [UPC_W-1:0] US_TGT_END   = 5'd6;
  localparam logic [UPC_W-1:0] US_TO_RELAY  = 5'd7;
  localparam logic [UPC_W-1:0] US_HDR_SOF   = 5'd8;
  localparam logic [UPC_W-1:0] US_HDR_CTRL  = 5'd9;
  localparam logic [UPC_W-1:0] US_HDR_LEN   = 5'd10;
  localparam logic [UPC_W-1:0] US_TO_PAY    = 5'd11;
  localparam logic [UPC_W-1:0] US_SUM       = 5'd12;
  localparam logic [UPC_W-1:0] US_END       = 5'd13;
  localparam logic [UPC_W-1:0] US_RLY       = 5'd14;
  localparam logic [UPC_W-1:0] US_RLY_TEST  = 5'd15;
  localparam logic [UPC_W-1:0] US_RLY_SOF   = 5'd16;
  localparam logic [UPC_W-1:0] US_RLY_CTRL  = 5'd17;
  localparam logic [UPC_W-1:0] US_RLY_LEN   = 5'd18;
  localparam logic [UPC_W-1:0] US_RLY_DONE  = 5'd19;
  localparam logic [UPC_W-1:0] US_STORE     = 5'd20;
  localparam logic [UPC_W-1:0] US_RLY_END   = 5'd21;
  localparam logic [UPC_W-1:0] US_RLY_PAY   = 5'd22;
  localparam logic [UPC_W-1:0] US_PAY       = 5'd23;
  localparam logic [UPC_W-1:0] US_PAY_TEST  = 5'd24;
  localparam logic [UPC_W-1:0] US_PAY_CLOSE = 5'd25;
  localparam logic [UPC_W-1:0] US_IDLE      = 5'd26;

  function automatic uword_t mfe_ucode(input logic [UPC_W-1:0] a);
    uword_t w;
    w = '0;
    case (a)
      US_FILL0: begin
        w.src = SRC_FILL; w.cs_clr = 1'b1;
      end
      US_FILL1: w.src = SRC_FILL;
      US_SOF: begin
        w.src = SRC_SOF; w.sum = 1'b1; w.bc_op = BC_CLR;
        w.ph_wr = 1'b1; w.ph = PH_TARGET; w.fin = 1'b1;
      end
      US_TGT: begin
        w.store_wr = 1'b1; w.bc_op = BC_INC;
        w.cond = COND_RELAYS_NZ; w.target = US_TGT_TEST;
      end
      US_TGT_EMIT: begin
        w.src = SRC_DATA; w.sum = 1'b1;
      end
      US_TGT_TEST: begin
        w.cond = COND_BC_NE_ADDR; w.target = US_IDLE;
      end
      US_TGT_END: begin
        w.bc_op = BC_CLR; w.cond = COND_RELAYS_ZERO; w.target = US_HDR_SOF;
      end
      US_TO_RELAY: begin
        w.ph_wr = 1'b1; w.ph = PH_RELAY; w.fin = 1'b1;
      end
      US_HDR_SOF: begin
        w.src = SRC_SOF; w.sum = 1'b1;
      end
      US_HDR_CTRL: begin
        w.src = SRC_CTRL; w.sum = 1'b1;
      end
      US_HDR_LEN: begin
        w.src = SRC_LEN; w.sum = 1'b1; w.cond = COND_LEN_ZERO; w.target = US_SUM;
      end
      US_TO_PAY: begin
        w.ph_wr = 1'b1; w.ph = PH_PAYLOAD; w.fin = 1'b1;
      end
      US_SUM: w.src = SRC_SUM;
      US_END: begin
        w.src = SRC_END; w.bc_op = BC_CLR;
        w.ph_wr = 1'b1; w.ph = PH_IDLE; w.fin = 1'b1;
      end
      US_RLY: begin
        w.src = SRC_RELAY; w.sum = 1'b1; w.bc_op = BC_INC;
      end
      US_RLY_TEST: begin
        w.cond = COND_BC_NE_ADDR; w.target = US_RLY_DONE;
      end
      US_RLY_SOF: begin
        w.src = SRC_SOF; w.sum = 1'b1;
      end
      US_RLY_CTRL: begin
        w.src = SRC_CTRL; w.sum = 1'b1;
      end
      US_RLY_LEN: begin
        w.src = SRC_LEN; w.sum = 1'b1;
      end
      US_RLY_DONE: begin
        w.idx_clr = 1'b1; w.cond = COND_BC_LT_RELAYS; w.target = US_IDLE;
      end
      US_STORE: begin
        w.src = SRC_STORE33; w.sum = 1'b1; w.idx_inc = 1'b1;
        w.cond = COND_IDX_NE_LAST; w.target = US_STORE;
      end
      US_RLY_END: begin
        w.bc_op = BC_CLR; w.cond = COND_LEN_ZERO; w.target = US_SUM;
      end
      US_RLY_PAY: begin
        w.ph_wr = 1'b1; w.ph = PH_PAYLOAD; w.fin = 1'b1;
      end
      US_PAY: begin
        w.src = SRC_DATA33; w.sum = 1'b1; w.bc_op = BC_INC;
      end
      US_PAY_TEST: begin
        w.cond = COND_BC_LT_LEN; w.target = US_IDLE;
      end
      US_PAY_CLOSE: begin
        w.cond = COND_ALWAYS; w.target = US_SUM;
      end
      default: w.fin = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/meter_frame_encoder.sv =====
// Meter link frame encoder: a microcoded sequencer steps through mfe_pkg's control store.
// Items: s_tready is low while the sequencer runs an item's control steps, so a new item is
// taken only after the last one finishes; each emitting step presents at most one byte, and a
// target address byte with no relays is stored before it is emitted. The longest run of steps
// is for the last address byte of a single relay hop with no payload; an item whose op does not
// match the phase is dropped without running any step; a full output register stalls emitting steps.
// Reset: synchronous; phase idle, counters, checksum and held fields cleared, output empty.
module meter_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,  // op[1:0]
  input  logic [23:0] s_tdata,  // data_byte[7:0], ctrl[12:8], relay_count[15:13],
                                // payload_length[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte[7:0]
  output logic        m_tlast
);
  import mfe_pkg::*;

  logic [1:0] op;
  logic [7:0] data_byte;
  logic [4:0] ctrl;
  logic [2:0] relay_count;
  logic [7:0] payload_length;

  assign op             = s_tuser;
  assign data_byte      = s_tdata[7:0];
  assign ctrl           = s_tdata[12:8];
  assign relay_count    = s_tdata[15:13];
  assign payload_length = s_tdata[23:16];

  phase_t           phase, phase_next;
  logic             busy, busy_next;
  logic [UPC_W-1:0] upc, upc_next;
  logic [7:0]       bc, bc_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [7:0]       cs, cs_next;
  logic [7:0]       data;
  logic [4:0]       held_ctrl;
  logic [2:0]       held_relays;
  logic [7:0]       held_length;
  logic [7:0]       store [ADDR_BYTES];

  uword_t     uw;
  logic       accept, matched, stall, step, jump;
  logic       emit;
  logic [7:0] emit_byte;
  logic [7:0] relay_end;
  phase_t     exp_phase;
  logic [UPC_W-1:0] entry;

  assign uw        = mfe_ucode(upc);
  assign s_tready  = !busy;
  assign accept    = s_tvalid && s_tready;
  assign relay_end = 8'(held_relays) * 8'(ADDR_BYTES);

  // routine entry for the current phase
  always_comb begin
    unique case (phase)
      PH_IDLE:    begin exp_phase = PH_IDLE;    entry = US_FILL0; end
      PH_TARGET:  begin exp_phase = PH_TARGET;  entry = US_TGT;   end
      PH_RELAY:   begin exp_phase = PH_RELAY;   entry = US_RLY;   end
      default:    begin exp_phase = PH_PAYLOAD; entry = US_PAY;   end
    endcase
  end
  assign matched = (op == 2'(exp_phase));

  // datapath byte selection
  always_comb begin
    case (uw.src)
      SRC_FILL:    emit_byte = FILL_BYTE;
      SRC_SOF:     emit_byte = SOF_BYTE;
      SRC_DATA:    emit_byte = data;
      SRC_DATA33:  emit_byte = data + BODY_OFFSET;
      SRC_RELAY:   emit_byte = (bc < 8'(ADDR_BYTES)) ? data : data + BODY_OFFSET;
      SRC_CTRL:    emit_byte = {held_relays, held_ctrl};
      SRC_LEN:     emit_byte = relay_end + held_length;
      SRC_STORE33: emit_byte = store[idx[IDX_W-1:0]] + BODY_OFFSET;
      SRC_SUM:     emit_byte = cs;
      SRC_END:     emit_byte = END_BYTE;
      default:     emit_byte = 8'd0;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:        jump = 1'b0;
      COND_ALWAYS:       jump = 1'b1;
      COND_RELAYS_ZERO:  jump = (held_relays == 3'd0);
      COND_RELAYS_NZ:    jump = (held_relays != 3'd0);
      COND_BC_NE_ADDR:   jump = (bc != 8'(ADDR_BYTES));
      COND_BC_LT_RELAYS: jump = (bc < relay_end);
      COND_LEN_ZERO:     jump = (held_length == 8'd0);
      COND_BC_LT_LEN:    jump = (bc < held_length);
      COND_IDX_NE_LAST:  jump = (idx != CNT_W'(ADDR_BYTES - 1));
      default:           jump = 1'b0;
    endcase
  end

  assign stall = (uw.src != SRC_NONE) && m_tvalid && !m_tready;
  assign step  = busy && !stall;
  assign emit  = step && (uw.src != SRC_NONE);

  // next control state
  always_comb begin
    busy_next  = busy;
    upc_next   = upc;
    phase_next = phase;
    bc_next    = bc;
    idx_next   = idx;
    cs_next    = cs;
    if (accept) begin
      busy_next = matched;
      upc_next  = entry;
    end else if (step) begin
      upc_next = jump ? uw.target : upc + UPC_W'(1);
      if (uw.fin) begin
        busy_next = 1'b0;
      end
      if (uw.ph_wr) begin
        phase_next = uw.ph;
      end
      case (uw.bc_op)
        BC_CLR:  bc_next = 8'd0;
        BC_INC:  bc_next = bc + 8'd1;
        default: bc_next = bc;
      endcase
      if (uw.idx_clr) begin
        idx_next = '0;
      end else if (uw.idx_inc) begin
        idx_next = idx + CNT_W'(1);
      end
      if (uw.cs_clr) begin
        cs_next = 8'd0;
      end else if (uw.sum) begin
        cs_next = cs + emit_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      upc         <= US_IDLE;
      phase       <= PH_IDLE;
      bc          <= 8'd0;
      idx         <= '0;
      cs          <= 8'd0;
      held_ctrl   <= 5'd0;
      held_relays <= 3'd0;
      held_length <= 8'd0;
      m_tvalid    <= 1'b0;
    end else begin
      busy  <= busy_next;
      upc   <= upc_next;
      phase <= phase_next;
      bc    <= bc_next;
      idx   <= idx_next;
      cs    <= cs_next;
      // latch frame parameters only on a start that is taken
      if (accept && matched && (phase == PH_IDLE)) begin
        held_ctrl   <= ctrl;
        held_relays <= relay_count;
        held_length <= payload_length;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      data <= data_byte;
    end
    if (step && uw.store_wr) begin
      store[bc[IDX_W-1:0]] <= data;
    end
    if (emit) begin
      m_tdata <= emit_byte;
      m_tlast <= (uw.src == SRC_END);
    end
  end

  // a pending closing byte means the frame is finished and no new one has started
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (phase == PH_IDLE))
    else $error("closing byte pending outside idle phase");

  // between relay items the count never reaches the end of the relay addresses
  a_relay_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RELAY && !busy) |-> (bc < relay_end))
    else $error("relay byte count past relay section");

  // target read index never exceeds the store depth
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= CNT_W'(ADDR_BYTES))
    else $error("target store index out of range");

  // the sequencer never runs off the end of the program
  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (upc <= US_IDLE))
    else $error("sequencer outside control store");

endmodule
